// ----- design/pcenc_pkg.sv -----
// Shared constants and helpers for the polar code encoder.
`default_nettype none

package pcenc_pkg;

  // Block size register: log2 of the code block length.
  localparam int unsigned CFG_W = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd6;

  // Default largest block length (bits).
  localparam int unsigned MAX_BLOCK_BITS_DEF = 64;

  // Reverse the low w bits of v.
  function automatic int bit_rev(input int v, input int w);
    int r;
    r = 0;
    for (int b = 0; b < w; b++) begin
      if (((v >> (w - 1 - b)) & 1) != 0) begin
        r = r | (1 << b);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/pcenc_queue.sv -----
// Two-entry block queue between the loader and the transform engine.
`default_nettype none

module pcenc_queue import pcenc_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      pop_data_o,
  output logic                   empty_o
);

  logic [DATA_W-1:0] entries_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("block queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("block pushed into a full queue");

endmodule

`default_nettype wire

// ----- design/pcenc_front.sv -----
// Loader: holds the block size register and gathers message bits into a block.
`default_nettype none

module pcenc_front import pcenc_pkg::*; #(
  parameter int unsigned MAX_BLOCK_BITS = MAX_BLOCK_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [CFG_W-1:0]              cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          message_bit_i,
  output logic                               in_stall_o,
  input  wire logic                          queue_full_i,
  output logic                               push_o,
  output logic [(1 << ($clog2(MAX_BLOCK_BITS + 1) - 1)) + CFG_W - 1:0] push_data_o
);

  localparam int unsigned KMAX     = $clog2(MAX_BLOCK_BITS + 1) - 1;
  localparam int unsigned BUF_BITS = 1 << KMAX;
  localparam int unsigned KW       = KMAX;

  logic [CFG_W-1:0]    cfg_q;
  logic [CFG_W-1:0]    k_eff;
  logic [KW:0]         n_full;
  logic [KW:0]         n_less;
  logic [KW-1:0]       cnt_q, cnt_d;
  logic [BUF_BITS-1:0] buf_q;
  logic [BUF_BITS-1:0] blk;
  logic                accept;
  logic                blk_done;

  // Clamp the register to the supported range of block sizes.
  always_comb begin
    if (cfg_q == '0) begin
      k_eff = CFG_W'(1);
    end else if (cfg_q > CFG_W'(KMAX)) begin
      k_eff = CFG_W'(KMAX);
    end else begin
      k_eff = cfg_q;
    end
  end

  assign n_full   = (KW + 1)'(1) << k_eff;
  assign n_less   = n_full - (KW + 1)'(1);
  assign accept   = in_valid_i && !queue_full_i;
  assign blk_done = (cnt_q == n_less[KW-1:0]);

  assign in_stall_o = queue_full_i;

  always_comb begin
    blk        = buf_q;
    blk[cnt_q] = message_bit_i;
  end

  assign push_o      = accept && blk_done;
  assign push_data_o = {blk, k_eff};

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_valid_i) begin
      // Drop any partial block.
      cnt_d = '0;
    end else if (accept) begin
      cnt_d = blk_done ? '0 : cnt_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
      cnt_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q[cnt_q] <= message_bit_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/pcenc_back.sv -----
// Transform engine: butterfly stages, bit-reversal reorder, serial bit output.
`default_nettype none

module pcenc_back import pcenc_pkg::*; #(
  parameter int unsigned MAX_BLOCK_BITS = MAX_BLOCK_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          queue_empty_i,
  input  wire logic [(1 << ($clog2(MAX_BLOCK_BITS + 1) - 1)) + CFG_W - 1:0] queue_data_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               code_bit_o,
  output logic                               last_bit_o
);

  localparam int unsigned KMAX     = $clog2(MAX_BLOCK_BITS + 1) - 1;
  localparam int unsigned BUF_BITS = 1 << KMAX;
  localparam int unsigned KW       = KMAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFORM,
    ST_PERM,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [BUF_BITS-1:0] data_q;
  logic [CFG_W-1:0]    k_q;
  logic [CFG_W-1:0]    stage_q;
  logic [KW-1:0]       rem_q;
  logic [BUF_BITS-1:0] xform;
  logic [BUF_BITS-1:0] perm;
  logic [KW:0]         n_full;
  logic [KW:0]         n_less;

  // One butterfly stage: fold the upper partner of each pair into the lower.
  always_comb begin
    xform = data_q;
    for (int i = 0; i < BUF_BITS; i++) begin
      for (int t = 0; t < KMAX; t++) begin
        if (stage_q == CFG_W'(t) && ((i >> t) & 1) == 0) begin
          xform[i] = data_q[i] ^ data_q[i | (1 << t)];
        end
      end
    end
  end

  // Put the transformed bits in bit-reversed order for the active block size.
  always_comb begin
    perm = '0;
    for (int kk = 1; kk <= KMAX; kk++) begin
      if (k_q == CFG_W'(kk)) begin
        for (int j = 0; j < (1 << kk); j++) begin
          perm[j] = data_q[bit_rev(j, kk)];
        end
      end
    end
  end

  assign n_full = (KW + 1)'(1) << k_q;
  assign n_less = n_full - (KW + 1)'(1);

  assign pop_o       = (state_q == ST_IDLE) && !queue_empty_i;
  assign out_valid_o = (state_q == ST_EMIT);
  assign code_bit_o  = data_q[0];
  assign last_bit_o  = (rem_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      data_q  <= '0;
      k_q     <= CFG_W'(1);
      stage_q <= '0;
      rem_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!queue_empty_i) begin
            data_q  <= queue_data_i[BUF_BITS+CFG_W-1:CFG_W];
            k_q     <= queue_data_i[CFG_W-1:0];
            stage_q <= '0;
            state_q <= ST_XFORM;
          end
        end
        ST_XFORM: begin
          data_q <= xform;
          if (stage_q == k_q - CFG_W'(1)) begin
            state_q <= ST_PERM;
          end else begin
            stage_q <= stage_q + CFG_W'(1);
          end
        end
        ST_PERM: begin
          data_q  <= perm;
          rem_q   <= n_less[KW-1:0];
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_stall_i) begin
            data_q <= data_q >> 1;
            if (rem_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              rem_q <= rem_q - KW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_stage_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_XFORM) |-> (stage_q < k_q))
    else $error("butterfly stage beyond block size");

  a_last_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_bit_o) |=> !out_valid_o)
    else $error("output still valid after last bit of block");

endmodule

`default_nettype wire

// ----- design/polar_code_encoder.sv -----
// Top level of the polar code encoder: loader, block queue and transform engine.
// Input: one message bit per cycle while the two-block queue has room.
// A block of n = 2^k bits passes through the engine in order: it is taken from
// the queue, then k butterfly stages, one reorder, then n output bits.
// The engine pops the next block only after the last bit of the current one.
// Reset (asynchronous, active low): block size 6, load count and queue cleared.
`default_nettype none

module polar_code_encoder import pcenc_pkg::*; #(
  parameter int unsigned MAX_BLOCK_BITS = MAX_BLOCK_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Block size register write
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  // Message bits in
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             message_bit_i,
  // Code bits out
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  code_bit_o,
  output logic                  last_bit_o
);

  localparam int unsigned KMAX     = $clog2(MAX_BLOCK_BITS + 1) - 1;
  localparam int unsigned BUF_BITS = 1 << KMAX;
  localparam int unsigned QW       = BUF_BITS + CFG_W;

  logic          push;
  logic [QW-1:0] push_data;
  logic          queue_full;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          queue_empty;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Gather message bits; hand a full block plus its size to the queue.
  pcenc_front #(
    .MAX_BLOCK_BITS(MAX_BLOCK_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .message_bit_i (message_bit_i),
    .in_stall_o    (in_stall_o),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // Hold up to two complete blocks so loading continues while the engine works.
  pcenc_queue #(
    .DATA_W(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (queue_empty)
  );

  // Run the butterfly stages, reorder and stream the codeword out.
  pcenc_back #(
    .MAX_BLOCK_BITS(MAX_BLOCK_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .queue_data_i  (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_bit_o    (code_bit_o),
    .last_bit_o    (last_bit_o)
  );

endmodule

`default_nettype wire
